// ----- design/bounded_sequence_store_assert.svh -----
// Assertion macros shared by the bounded_sequence_store checker.
// Depends on a clk and rst in the scope of each use.
`ifndef BOUNDED_SEQUENCE_STORE_ASSERT_SVH
`define BOUNDED_SEQUENCE_STORE_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define BSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_sequence_store check failed");

// Next-cycle implication, disabled in reset
`define BSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_sequence_store check failed");

`endif

// ----- design/bss_pkg.sv -----
// Shared types and constants for the bounded sequence store.
// No dependencies; used by datapath, controller, top level and checker.
package bss_pkg;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 9;
  localparam int DATA_W = 32;
  localparam int ERR_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic take_in;   // latch the input beat
    logic check;     // range check, load move pointers
    logic move;      // stream one shift move per cycle
    logic read_pos;  // read the entry at position
    logic commit;    // update count/store, load result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_error;
    logic is_read;
    logic needs_move;
    logic moves_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- design/bss_datapath.sv -----
// Datapath of the bounded sequence store: element memory, count, move
// pointers and the result register. Depends on bss_pkg.
module bss_datapath #(
  parameter int CAPACITY = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bss_pkg::ctrl_cmd_t                   ctl,
  output bss_pkg::ctrl_stat_t                  sts,
  input  logic [bss_pkg::CMD_W-1:0]            cmd,
  input  logic [bss_pkg::POS_W-1:0]            position,
  input  logic [bss_pkg::POS_W-1:0]            erase_count,
  input  logic signed [bss_pkg::DATA_W-1:0]    value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bss_pkg::DATA_W-1:0]    read_data,
  output logic [bss_pkg::POS_W-1:0]            stored_count,
  output logic                                 is_empty,
  output logic [bss_pkg::ERR_W-1:0]            error_code
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = bss_pkg::POS_W;
  localparam int DW = bss_pkg::DATA_W;
  localparam int XW = (CW > PW + 1) ? CW : PW + 1;

  // Latched command
  logic [bss_pkg::CMD_W-1:0] cmd_q;
  logic [PW-1:0]             pos_q;
  logic [PW-1:0]             run_q;
  logic [DW-1:0]             val_q;
  logic [bss_pkg::ERR_W-1:0] err_q;

  // Sequence state and move engine
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] moves;
  logic [AW-1:0] src;
  logic [AW-1:0] dst;
  logic          move_up;
  logic          pend;
  logic [DW-1:0] rd_q;
  logic [DW-1:0] mem [CAPACITY];

  // Check-stage values
  logic [XW-1:0]             pos_x;
  logic [XW-1:0]             count_x;
  logic [XW-1:0]             end_x;
  logic                      full;
  logic                      empty;
  logic [bss_pkg::ERR_W-1:0] err_chk;
  logic [CW-1:0]             moves_init;
  logic [AW-1:0]             src_init;
  logic [AW-1:0]             dst_init;

  // Memory port control
  logic          step;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          commit_ok;

  assign pos_x   = XW'(pos_q);
  assign count_x = XW'(count);
  assign end_x   = pos_x + XW'(run_q);
  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);

  // Error check and move setup
  always_comb begin
    err_chk    = bss_pkg::ERR_OK;
    moves_init = '0;
    src_init   = AW'(count_x - XW'(1));
    dst_init   = AW'(count_x);
    unique case (cmd_q)
      bss_pkg::CMD_APPEND: begin
        if (full) err_chk = bss_pkg::ERR_FULL;
      end
      bss_pkg::CMD_REMOVE, bss_pkg::CMD_CLEAR: begin
        if (empty) err_chk = bss_pkg::ERR_EMPTY;
      end
      bss_pkg::CMD_INSERT: begin
        if (pos_x > count_x)  err_chk = bss_pkg::ERR_RANGE;
        else if (full)        err_chk = bss_pkg::ERR_FULL;
        moves_init = CW'(count_x - pos_x);
      end
      bss_pkg::CMD_ERASE: begin
        if (end_x > count_x) err_chk = bss_pkg::ERR_RANGE;
        else if (run_q != '0) moves_init = CW'(count_x - end_x);
        src_init = AW'(end_x);
        dst_init = AW'(pos_x);
      end
      bss_pkg::CMD_READ, bss_pkg::CMD_WRITE: begin
        if (empty)                err_chk = bss_pkg::ERR_EMPTY;
        else if (pos_x >= count_x) err_chk = bss_pkg::ERR_RANGE;
      end
      default: err_chk = bss_pkg::ERR_OK;
    endcase
  end

  assign sts.has_error  = (err_chk != bss_pkg::ERR_OK);
  assign sts.is_read    = (cmd_q == bss_pkg::CMD_READ);
  assign sts.needs_move = (moves_init != '0) && (err_chk == bss_pkg::ERR_OK);
  assign sts.moves_done = (moves == '0);
  assign sts.out_free   = !out_valid || out_ready;

  assign commit_ok = ctl.commit && (err_q == bss_pkg::ERR_OK);

  // Count after commit
  always_comb begin
    count_next = count;
    if (err_q == bss_pkg::ERR_OK) begin
      unique case (cmd_q)
        bss_pkg::CMD_APPEND, bss_pkg::CMD_INSERT: count_next = count + CW'(1);
        bss_pkg::CMD_REMOVE: count_next = count - CW'(1);
        bss_pkg::CMD_ERASE:  count_next = count - CW'(run_q);
        bss_pkg::CMD_CLEAR:  count_next = '0;
        default:             count_next = count;
      endcase
    end
  end

  // Memory port selection: shift moves or commit write
  assign step    = ctl.move && (moves != '0);
  assign rd_en   = step || ctl.read_pos;
  assign rd_addr = ctl.read_pos ? AW'(pos_q) : src;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dst;
    wr_data = rd_q;
    if (pend) begin
      wr_en = 1'b1;
    end else if (commit_ok && (cmd_q == bss_pkg::CMD_APPEND)) begin
      wr_en   = 1'b1;
      wr_addr = AW'(count);
      wr_data = val_q;
    end else if (commit_ok && ((cmd_q == bss_pkg::CMD_INSERT) ||
                               (cmd_q == bss_pkg::CMD_WRITE))) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos_q);
      wr_data = val_q;
    end
  end

  // Element memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Command latch and move pointers
  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      cmd_q <= cmd;
      pos_q <= position;
      run_q <= erase_count;
      val_q <= value;
    end
    if (ctl.check) begin
      err_q   <= err_chk;
      moves   <= moves_init;
      src     <= src_init;
      dst     <= dst_init;
      move_up <= (cmd_q == bss_pkg::CMD_ERASE);
    end else begin
      if (step) begin
        src   <= move_up ? src + AW'(1) : src - AW'(1);
        moves <= moves - CW'(1);
      end
      if (pend) dst <= move_up ? dst + AW'(1) : dst - AW'(1);
    end
  end

  // Control state: count, write-pending flag, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= step;
      if (ctl.commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      read_data    <= ((cmd_q == bss_pkg::CMD_READ) && (err_q == bss_pkg::ERR_OK))
                      ? rd_q : '0;
      stored_count <= PW'(count_next);
      is_empty     <= (count_next == '0);
      error_code   <= err_q;
    end
  end

endmodule

// ----- design/bss_ctrl.sv -----
// Controller of the bounded sequence store: sequences check, shift moves,
// reads and the commit. Depends on bss_pkg.
module bss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bss_pkg::ctrl_stat_t sts,
  output bss_pkg::ctrl_cmd_t  ctl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_MOVE   = 5'b00100,
    S_READ   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    ctl          = '0;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctl.take_in = in_valid;
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        ctl.check = 1'b1;
        priority if (sts.has_error) state_next = S_FINISH;
        else if (sts.is_read)       state_next = S_READ;
        else if (sts.needs_move)    state_next = S_MOVE;
        else                        state_next = S_FINISH;
      end
      S_MOVE: begin
        ctl.move = 1'b1;
        if (sts.moves_done) state_next = S_FINISH;
      end
      S_READ: begin
        ctl.read_pos = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/bounded_sequence_store.sv -----
// Bounded sequence store: one command beat in, one result beat out.
// Each command is checked; reads then fetch the entry, and insert and erase shift
// the affected entries, one move per cycle, before the commit.
// One command in flight; a stalled result delays its commit and so the next accept.
// Reset clears the count, controller and result valid; memory is not cleared.
module bounded_sequence_store #(
  parameter int CAPACITY = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bss_pkg::CMD_W-1:0]            cmd,
  input  logic [bss_pkg::POS_W-1:0]            position,
  input  logic [bss_pkg::POS_W-1:0]            erase_count,
  input  logic signed [bss_pkg::DATA_W-1:0]    value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bss_pkg::DATA_W-1:0]    read_data,
  output logic [bss_pkg::POS_W-1:0]            stored_count,
  output logic                                 is_empty,
  output logic [bss_pkg::ERR_W-1:0]            error_code
);

  bss_pkg::ctrl_cmd_t  ctl;
  bss_pkg::ctrl_stat_t sts;

  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bss_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cmd          (cmd),
    .position     (position),
    .erase_count  (erase_count),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .stored_count (stored_count),
    .is_empty     (is_empty),
    .error_code   (error_code)
  );

endmodule

// ----- design/bss_checker.sv -----
// Port-level checks for bounded_sequence_store, bound to the top level.
// Depends on bss_pkg and bounded_sequence_store_assert.svh.
`include "bounded_sequence_store_assert.svh"

module bss_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bss_pkg::DATA_W-1:0] read_data,
  input logic [bss_pkg::POS_W-1:0]         stored_count,
  input logic                              is_empty,
  input logic [bss_pkg::ERR_W-1:0]         error_code
);

  // One command in flight: no accept right after an accept
  `BSS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // Empty flag agrees with the reported count
  `BSS_ASSERT_IMP(a_empty_count, out_valid && is_empty, stored_count == '0)

  // Only a successful command carries read data
  `BSS_ASSERT_IMP(a_data_ok, out_valid && (read_data != '0), error_code == bss_pkg::ERR_OK)

  // An empty error always leaves the store empty
  `BSS_ASSERT_IMP(a_empty_err, out_valid && (error_code == bss_pkg::ERR_EMPTY), is_empty)

  // Stalled result beat holds
  `BSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(error_code))

endmodule

bind bounded_sequence_store bss_checker u_bss_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_data    (read_data),
  .stored_count (stored_count),
  .is_empty     (is_empty),
  .error_code   (error_code)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bounded_sequence_store: directed command table, then paced
// random streams with fill-to-capacity runs, checked by typed rows or a shadow model.
// Depends on bss_pkg and the bounded_sequence_store RTL.
module tb;

  localparam int CAPACITY    = 256;
  localparam int STALL_LIMIT = 5000;  // cycles with no beat on either channel
  localparam int TAIL_CYCLES = 300;   // worst insert/erase latency plus margin
  localparam int HOLD_CYCLES = 400;   // long output hold-off
  localparam int PHASE_BEATS = 375;
  localparam logic [bss_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [bss_pkg::CMD_W-1:0]         cmd;
    logic [bss_pkg::POS_W-1:0]         position;
    logic [bss_pkg::POS_W-1:0]         erase_count;
    logic signed [bss_pkg::DATA_W-1:0] value;
  } seq_cmd_t;

  typedef struct packed {
    logic signed [bss_pkg::DATA_W-1:0] read_data;
    logic [bss_pkg::POS_W-1:0]         stored_count;
    logic                              is_empty;
    logic [bss_pkg::ERR_W-1:0]         error_code;
  } seq_result_t;

  typedef struct packed {
    seq_cmd_t    beat;
    logic        typed;   // expected result written into the table
    seq_result_t want;
  } directed_row_t;

  logic                              clk         = 1'b0;
  logic                              rst         = 1'b1;
  logic                              in_valid    = 1'b0;
  logic                              in_ready;
  logic [bss_pkg::CMD_W-1:0]         cmd         = '0;
  logic [bss_pkg::POS_W-1:0]         position    = '0;
  logic [bss_pkg::POS_W-1:0]         erase_count = '0;
  logic signed [bss_pkg::DATA_W-1:0] value       = '0;
  logic                              out_valid;
  logic                              out_ready   = 1'b0;
  logic signed [bss_pkg::DATA_W-1:0] read_data;
  logic [bss_pkg::POS_W-1:0]         stored_count;
  logic                              is_empty;
  logic [bss_pkg::ERR_W-1:0]         error_code;

  // Shadow copy of the sequence
  logic [bss_pkg::DATA_W-1:0] shadow_elems [CAPACITY];
  int                         shadow_count = 0;

  seq_result_t awaited_results [$];
  int          mismatch_count  = 0;
  int          beats_sent      = 0;
  int          results_checked = 0;
  int          fills_done      = 0;
  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  bit          hold_req           = 1'b0;

  always #4 clk = ~clk;

  bounded_sequence_store #(.CAPACITY(CAPACITY)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .position     (position),
    .erase_count  (erase_count),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .stored_count (stored_count),
    .is_empty     (is_empty),
    .error_code   (error_code)
  );

  // Apply one command to the shadow sequence and return the result it gives
  function automatic seq_result_t apply_to_shadow(input seq_cmd_t c);
    seq_result_t r;
    int p, n, i;
    r            = '0;
    r.error_code = bss_pkg::ERR_OK;
    p            = int'(c.position);
    n            = int'(c.erase_count);
    case (c.cmd)
      bss_pkg::CMD_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.error_code = bss_pkg::ERR_FULL;
        end else begin
          shadow_elems[shadow_count] = c.value;
          shadow_count++;
        end
      end
      bss_pkg::CMD_REMOVE: begin
        if (shadow_count == 0) r.error_code = bss_pkg::ERR_EMPTY;
        else shadow_count--;
      end
      bss_pkg::CMD_INSERT: begin
        if (p > shadow_count) begin
          r.error_code = bss_pkg::ERR_RANGE;
        end else if (shadow_count >= CAPACITY) begin
          r.error_code = bss_pkg::ERR_FULL;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_elems[i] = shadow_elems[i-1];
          shadow_elems[p] = c.value;
          shadow_count++;
        end
      end
      bss_pkg::CMD_ERASE: begin
        if (p + n > shadow_count) begin
          r.error_code = bss_pkg::ERR_RANGE;
        end else if (n != 0) begin
          for (i = p; i + n < shadow_count; i++) shadow_elems[i] = shadow_elems[i+n];
          shadow_count -= n;
        end
      end
      bss_pkg::CMD_READ, bss_pkg::CMD_WRITE: begin
        if (shadow_count == 0) r.error_code = bss_pkg::ERR_EMPTY;
        else if (p >= shadow_count) r.error_code = bss_pkg::ERR_RANGE;
        else if (c.cmd == bss_pkg::CMD_READ) r.read_data = shadow_elems[p];
        else shadow_elems[p] = c.value;
      end
      bss_pkg::CMD_CLEAR: begin
        if (shadow_count == 0) r.error_code = bss_pkg::ERR_EMPTY;
        else shadow_count = 0;
      end
      default: ;  // unused code: no effect
    endcase
    r.stored_count = bss_pkg::POS_W'(shadow_count);
    r.is_empty     = (shadow_count == 0);
    return r;
  endfunction

  function automatic seq_cmd_t beat_of(input logic [bss_pkg::CMD_W-1:0] c, input int p,
                                       input int n, input logic [bss_pkg::DATA_W-1:0] v);
    seq_cmd_t b;
    b.cmd         = c;
    b.position    = bss_pkg::POS_W'(p);
    b.erase_count = bss_pkg::POS_W'(n);
    b.value       = v;
    return b;
  endfunction

  function automatic directed_row_t row(input logic [bss_pkg::CMD_W-1:0] c, input int p,
                                        input int n, input logic [bss_pkg::DATA_W-1:0] v,
                                        input bit typed,
                                        input logic [bss_pkg::DATA_W-1:0] rd, input int cnt,
                                        input logic [bss_pkg::ERR_W-1:0] err);
    directed_row_t t;
    t.beat              = beat_of(c, p, n, v);
    t.typed             = typed;
    t.want.read_data    = rd;
    t.want.stored_count = bss_pkg::POS_W'(cnt);
    t.want.is_empty     = (cnt == 0);
    t.want.error_code   = err;
    return t;
  endfunction

  // Random command, mostly well-formed against the current shadow count
  function automatic seq_cmd_t random_command();
    seq_cmd_t b;
    int r, lim;
    r = $urandom_range(99);
    if      (r < 24) b.cmd = bss_pkg::CMD_APPEND;
    else if (r < 32) b.cmd = bss_pkg::CMD_REMOVE;
    else if (r < 50) b.cmd = bss_pkg::CMD_INSERT;
    else if (r < 62) b.cmd = bss_pkg::CMD_ERASE;
    else if (r < 80) b.cmd = bss_pkg::CMD_READ;
    else if (r < 94) b.cmd = bss_pkg::CMD_WRITE;
    else if (r < 97) b.cmd = bss_pkg::CMD_CLEAR;
    else             b.cmd = CMD_UNUSED;
    // keep the sequence short so shifts stay cheap
    if (shadow_count > 40 &&
        (b.cmd == bss_pkg::CMD_APPEND || b.cmd == bss_pkg::CMD_INSERT) &&
        $urandom_range(1) == 1)
      b.cmd = bss_pkg::CMD_ERASE;
    lim = (b.cmd == bss_pkg::CMD_INSERT || b.cmd == bss_pkg::CMD_ERASE) ?
          shadow_count : shadow_count - 1;
    if (lim >= 0 && $urandom_range(99) < 85)
      b.position = bss_pkg::POS_W'($urandom_range(lim, 0));
    else
      b.position = bss_pkg::POS_W'($urandom_range(511, 0));
    if (int'(b.position) <= shadow_count && $urandom_range(99) < 85)
      b.erase_count = bss_pkg::POS_W'($urandom_range(shadow_count - int'(b.position), 0));
    else
      b.erase_count = bss_pkg::POS_W'($urandom_range(511, 0));
    case ($urandom_range(9))
      0:       b.value = 32'h8000_0000;
      1:       b.value = 32'h7FFF_FFFF;
      2:       b.value = '0;
      3:       b.value = '1;
      default: b.value = $urandom;
    endcase
    return b;
  endfunction

  // Offer one command beat; on accept, queue the expected result
  task automatic send_beat(input seq_cmd_t b, input bit typed, input seq_result_t want);
    seq_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= b.cmd;
    position    <= b.position;
    erase_count <= b.erase_count;
    value       <= b.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_to_shadow(b);
    awaited_results = {awaited_results, (typed ? want : predicted)};
    beats_sent++;
  endtask

  // Fill to capacity, hit the full-store cases and the longest shifts, then empty
  task automatic fill_to_capacity(input bit end_with_clear);
    int k;
    while (shadow_count < CAPACITY)
      send_beat(beat_of(bss_pkg::CMD_APPEND, 0, 0, $urandom), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_APPEND, 0, 0, $urandom), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_INSERT, 0, 0, $urandom), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_INSERT, CAPACITY, 0, $urandom), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_INSERT, CAPACITY + 1, 0, $urandom), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_WRITE, CAPACITY - 1, 0, $urandom), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_READ, CAPACITY - 1, 0, 0), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_READ, CAPACITY, 0, 0), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_ERASE, 0, 1, 0), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_INSERT, 0, 0, $urandom), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_ERASE, CAPACITY - 1, 1, 0), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_INSERT, CAPACITY - 1, 0, $urandom), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_ERASE, CAPACITY, 0, 0), 1'b0, '0);
    send_beat(beat_of(bss_pkg::CMD_ERASE, 1, CAPACITY, 0), 1'b0, '0);
    for (k = 0; k < 8; k++)
      send_beat(beat_of(bss_pkg::CMD_READ, $urandom_range(CAPACITY - 1, 0), 0, 0), 1'b0, '0);
    if (end_with_clear) send_beat(beat_of(bss_pkg::CMD_CLEAR, 0, 0, 0), 1'b0, '0);
    else send_beat(beat_of(bss_pkg::CMD_ERASE, 0, CAPACITY, 0), 1'b0, '0);
    fills_done++;
  endtask

  // Stimulus: reset, directed table, then four pacing phases of random commands
  initial begin : stimulus
    directed_row_t rows [$];
    int send_pct [4];
    int recv_pct [4];
    int phase, phase_start;
    bit filled;
    send_pct = '{0, 79, 0, 28};
    recv_pct = '{0, 0, 79, 28};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty-store errors, extremes, insert at the count, unused code
    rows = {rows, row(bss_pkg::CMD_READ, 0, 0, 32'h0, 1, 32'h0, 0, bss_pkg::ERR_EMPTY)};
    rows = {rows, row(bss_pkg::CMD_WRITE, 0, 0, 32'h1, 1, 32'h0, 0, bss_pkg::ERR_EMPTY)};
    rows = {rows, row(bss_pkg::CMD_REMOVE, 0, 0, 32'h0, 1, 32'h0, 0, bss_pkg::ERR_EMPTY)};
    rows = {rows, row(bss_pkg::CMD_CLEAR, 0, 0, 32'h0, 1, 32'h0, 0, bss_pkg::ERR_EMPTY)};
    rows = {rows, row(bss_pkg::CMD_ERASE, 0, 0, 32'h0, 1, 32'h0, 0, bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_ERASE, 1, 0, 32'h0, 1, 32'h0, 0, bss_pkg::ERR_RANGE)};
    rows = {rows, row(bss_pkg::CMD_INSERT, 1, 0, 32'h5, 1, 32'h0, 0, bss_pkg::ERR_RANGE)};
    rows = {rows, row(bss_pkg::CMD_INSERT, 0, 0, 32'h8000_0000, 1, 32'h0, 1,
                      bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_APPEND, 0, 0, 32'h7FFF_FFFF, 1, 32'h0, 2,
                      bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_READ, 0, 0, 32'h0, 1, 32'h8000_0000, 2,
                      bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_READ, 1, 0, 32'h0, 1, 32'h7FFF_FFFF, 2,
                      bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_READ, 2, 0, 32'h0, 1, 32'h0, 2, bss_pkg::ERR_RANGE)};
    rows = {rows, row(bss_pkg::CMD_READ, 511, 0, 32'h0, 1, 32'h0, 2, bss_pkg::ERR_RANGE)};
    rows = {rows, row(bss_pkg::CMD_WRITE, 1, 0, 32'hFFFF_FFFF, 1, 32'h0, 2,
                      bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_INSERT, 2, 0, 32'h0, 0, 32'h0, 0, bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_INSERT, 1, 0, 32'h5A5A_5A5A, 0, 32'h0, 0,
                      bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_READ, 1, 0, 32'h0, 0, 32'h0, 0, bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_READ, 3, 0, 32'h0, 0, 32'h0, 0, bss_pkg::ERR_OK)};
    rows = {rows, row(CMD_UNUSED, 511, 511, 32'h1234_5678, 1, 32'h0, 4, bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_ERASE, 1, 2, 32'h0, 0, 32'h0, 0, bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_ERASE, 0, 3, 32'h0, 1, 32'h0, 2, bss_pkg::ERR_RANGE)};
    rows = {rows, row(bss_pkg::CMD_ERASE, 511, 511, 32'h0, 1, 32'h0, 2,
                      bss_pkg::ERR_RANGE)};
    rows = {rows, row(bss_pkg::CMD_READ, 1, 0, 32'h0, 0, 32'h0, 0, bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_CLEAR, 0, 0, 32'h0, 1, 32'h0, 0, bss_pkg::ERR_OK)};
    rows = {rows, row(bss_pkg::CMD_APPEND, 0, 0, 32'h1, 0, 32'h0, 0, bss_pkg::ERR_OK)};
    foreach (rows[k]) send_beat(rows[k].beat, rows[k].typed, rows[k].want);

    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = send_pct[phase];
      receiver_stall_pct = recv_pct[phase];
      if (phase == 0) hold_req = 1'b1;  // back up the block while commands keep coming
      phase_start = beats_sent;
      filled      = 1'b0;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if (!filled && (phase == 0 || phase == 2) && beats_sent - phase_start >= 120) begin
          fill_to_capacity(phase == 2);
          filled = 1'b1;
        end else begin
          send_beat(random_command(), 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Summary: %0d command beats, %0d results checked, %0d runs to full capacity.",
             beats_sent, results_checked, fills_done);
    $display("Pacing: free running, sparse sender, stalling receiver, both, one long hold-off.");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, compare against the oldest expectation
  initial begin : result_side
    seq_result_t want;
    int hold_left;
    hold_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing expected");
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", $signed(want.read_data),
                   $signed(read_data));
            mismatch_count++;
          end
          if (stored_count !== want.stored_count) begin
            $error("stored_count: expected %0d, got %0d", want.stored_count, stored_count);
            mismatch_count++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
            mismatch_count++;
          end
          if (error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, error_code);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Watchdog: no beat on either channel for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
